// ===== rtl/rau_pkg.sv =====
// rau_pkg: shared types and constants for the rational arithmetic unit.
// Holds operand and result structs, opcode codes and derived widths.
// No dependencies.
package rau_pkg;

  localparam int FIELD_WIDTH = 16;
  localparam int NUM_W       = FIELD_WIDTH;
  localparam int DEN_W       = FIELD_WIDTH - 1;
  localparam int RES_NUM_W   = 32;
  localparam int RES_DEN_W   = 30;

  // working widths: signed numerator, denominator product, magnitude
  localparam int ACC_W  = 2 * FIELD_WIDTH;
  localparam int DPR_W  = 2 * FIELD_WIDTH - 2;
  localparam int MAG_W  = ACC_W;
  localparam int MUL_W  = FIELD_WIDTH + 1;
  localparam int PROD_W = 2 * MUL_W;
  localparam int SUB_W  = MAG_W + 2;
  localparam int K_W    = $clog2(DPR_W + 1);
  localparam int CNT_W  = $clog2(MAG_W + 1);

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_MUL = 2'd1;
  localparam logic [1:0] OP_EQU = 2'd2;
  localparam logic [1:0] OP_INC = 2'd3;

  typedef struct packed {
    logic [1:0]              req_type;
    logic signed [NUM_W-1:0] a_num;
    logic [DEN_W-1:0]        a_den;
    logic signed [NUM_W-1:0] b_num;
    logic [DEN_W-1:0]        b_den;
  } rau_req_t;

  typedef struct packed {
    logic signed [RES_NUM_W-1:0] res_num;
    logic [RES_DEN_W-1:0]        res_den;
    logic                        is_equal;
  } rau_res_t;

endpackage

// ===== rtl/rational_arith_unit_core.sv =====
// rational_arith_unit_core: add, multiply, compare and increment on fractions,
// with the result reduced by its greatest common divisor.
// Depends on rau_pkg.
//
// Usage: drive in_req and pulse start while busy is low; the item is taken
// at that edge and busy rises until the result has been shown. The result
// appears on out_res for exactly one cycle, marked by out_valid; the receiver
// must take it then, it cannot hold the block off.
// A compare is decided as the item is taken. Add and multiply first form numerator
// and denominator on one shared signed multiplier (add in states MUL_A, MUL_B
// and MUL_D, multiply in MUL_A and MUL_D; increment forms them as the item is
// taken), then run a binary GCD on one shared subtractor (one shift or subtract
// per cycle), restore the common powers of two, then divide numerator magnitude
// and denominator by the divisor with the same subtractor, one quotient bit per
// cycle. A zero numerator or denominator skips reduction. One item is in flight
// at a time. Synchronous active-low reset returns the sequencer to idle and
// drops any item in progress.
module rational_arith_unit_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  rau_pkg::rau_req_t in_req,
  output logic              out_valid,
  output rau_pkg::rau_res_t out_res
);
  import rau_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_MUL_A = 8'b0000_0010,
    ST_MUL_B = 8'b0000_0100,
    ST_MUL_D = 8'b0000_1000,
    ST_PREP  = 8'b0001_0000,
    ST_GCD   = 8'b0010_0000,
    ST_GFIX  = 8'b0100_0000,
    ST_DIV   = 8'b1000_0000
  } state_t;

  state_t                   state_r, state_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic                     div_den_r, div_den_nxt;
  rau_req_t                 req_r, req_nxt;
  rau_res_t                 out_r, out_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic signed [ACC_W-1:0]  num_r, num_nxt;
  logic [DPR_W-1:0]         den_r, den_nxt;
  logic [MAG_W-1:0]         u_r, u_nxt;
  logic [MAG_W-1:0]         v_r, v_nxt;
  logic [MAG_W-1:0]         mag_r, mag_nxt;
  logic [MAG_W-1:0]         q_r, q_nxt;
  logic [MAG_W-1:0]         rem_r, rem_nxt;
  logic [K_W-1:0]           k_r, k_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic                     neg_r, neg_nxt;

  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  logic [SUB_W-1:0]         sub_a, sub_b, sub_d;
  logic                     borrow;
  logic [MAG_W:0]           div_t;
  logic [MAG_W-1:0]         q_step;
  logic [MAG_W-1:0]         mag_fin;

  // shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_MUL_A: begin
        mul_a = MUL_W'(req_r.a_num);
        mul_b = (req_r.req_type == OP_MUL) ? MUL_W'(req_r.b_num)
                                           : signed'(MUL_W'(req_r.b_den));
      end
      ST_MUL_B: begin
        mul_a = MUL_W'(req_r.b_num);
        mul_b = signed'(MUL_W'(req_r.a_den));
      end
      ST_MUL_D: begin
        mul_a = signed'(MUL_W'(req_r.a_den));
        mul_b = signed'(MUL_W'(req_r.b_den));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

  // shared subtractor: GCD step or restoring division step
  assign div_t = {rem_r, q_r[MAG_W-1]};

  always_comb begin
    if (state_r == ST_DIV) begin
      sub_a = SUB_W'(div_t);
      sub_b = SUB_W'(u_r);
    end else begin
      sub_a = SUB_W'(u_r);
      sub_b = SUB_W'(v_r);
    end
  end

  assign sub_d  = sub_a - sub_b;
  assign borrow = sub_d[SUB_W-1];
  assign q_step = {q_r[MAG_W-2:0], ~borrow};
  assign mag_fin = div_den_r ? mag_r : q_step;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    div_den_nxt   = div_den_r;
    req_nxt       = req_r;
    out_nxt       = out_r;
    acc_nxt       = acc_r;
    num_nxt       = num_r;
    den_nxt       = den_r;
    u_nxt         = u_r;
    v_nxt         = v_r;
    mag_nxt       = mag_r;
    q_nxt         = q_r;
    rem_nxt       = rem_r;
    k_nxt         = k_r;
    cnt_nxt       = cnt_r;
    neg_nxt       = neg_r;

    unique case (state_r)
      ST_IDLE: begin
        if (start && !out_valid_r) begin
          req_nxt = in_req;
          unique case (in_req.req_type)
            OP_EQU: begin
              out_nxt.res_num  = '0;
              out_nxt.res_den  = '0;
              out_nxt.is_equal = (in_req.a_num == in_req.b_num) &&
                                 (in_req.a_den == in_req.b_den);
              out_valid_nxt    = 1'b1;
            end
            OP_INC: begin
              num_nxt   = ACC_W'(in_req.a_num) + signed'(ACC_W'(in_req.a_den));
              den_nxt   = DPR_W'(in_req.a_den);
              state_nxt = ST_PREP;
            end
            default: state_nxt = ST_MUL_A;
          endcase
        end
      end
      ST_MUL_A: begin
        if (req_r.req_type == OP_MUL) begin
          num_nxt   = ACC_W'(prod);
          state_nxt = ST_MUL_D;
        end else begin
          acc_nxt   = ACC_W'(prod);
          state_nxt = ST_MUL_B;
        end
      end
      ST_MUL_B: begin
        num_nxt   = acc_r + ACC_W'(prod);
        state_nxt = ST_MUL_D;
      end
      ST_MUL_D: begin
        den_nxt   = DPR_W'(prod);
        state_nxt = ST_PREP;
      end
      ST_PREP: begin
        if (num_r == '0 || den_r == '0) begin
          // pass through unreduced
          out_nxt.res_num  = RES_NUM_W'(num_r);
          out_nxt.res_den  = RES_DEN_W'(den_r);
          out_nxt.is_equal = 1'b0;
          out_valid_nxt    = 1'b1;
          state_nxt        = ST_IDLE;
        end else begin
          neg_nxt   = num_r[ACC_W-1];
          mag_nxt   = num_r[ACC_W-1] ? MAG_W'(-num_r) : MAG_W'(num_r);
          u_nxt     = num_r[ACC_W-1] ? MAG_W'(-num_r) : MAG_W'(num_r);
          v_nxt     = MAG_W'(den_r);
          k_nxt     = '0;
          state_nxt = ST_GCD;
        end
      end
      ST_GCD: begin
        if (u_r == v_r) begin
          state_nxt = ST_GFIX;
        end else if (!u_r[0] && !v_r[0]) begin
          u_nxt = u_r >> 1;
          v_nxt = v_r >> 1;
          k_nxt = k_r + K_W'(1);
        end else if (!u_r[0]) begin
          u_nxt = u_r >> 1;
        end else if (!v_r[0]) begin
          v_nxt = v_r >> 1;
        end else if (!borrow) begin
          u_nxt = sub_d[MAG_W-1:0];
        end else begin
          v_nxt = MAG_W'(-sub_d);
        end
      end
      ST_GFIX: begin
        // restore common powers of two; u then holds the divisor
        if (k_r != '0) begin
          u_nxt = u_r << 1;
          k_nxt = k_r - K_W'(1);
        end else begin
          q_nxt       = mag_r;
          rem_nxt     = '0;
          cnt_nxt     = '0;
          div_den_nxt = 1'b0;
          state_nxt   = ST_DIV;
        end
      end
      ST_DIV: begin
        q_nxt   = q_step;
        rem_nxt = borrow ? div_t[MAG_W-1:0] : sub_d[MAG_W-1:0];
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(MAG_W - 1)) begin
          cnt_nxt = '0;
          rem_nxt = '0;
          if (!div_den_r) begin
            mag_nxt     = q_step;
            q_nxt       = MAG_W'(den_r);
            div_den_nxt = 1'b1;
          end else begin
            out_nxt.res_num  = neg_r ? RES_NUM_W'(-signed'(mag_fin))
                                     : RES_NUM_W'(mag_fin);
            out_nxt.res_den  = RES_DEN_W'(q_step);
            out_nxt.is_equal = 1'b0;
            out_valid_nxt    = 1'b1;
            state_nxt        = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      div_den_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      div_den_r   <= div_den_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt;
    out_r <= out_nxt;
    acc_r <= acc_nxt;
    num_r <= num_nxt;
    den_r <= den_nxt;
    u_r   <= u_nxt;
    v_r   <= v_nxt;
    mag_r <= mag_nxt;
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    k_r   <= k_nxt;
    cnt_r <= cnt_nxt;
    neg_r <= neg_nxt;
  end

  // busy covers the result cycle so the next item waits for the strobe
  assign busy      = (state_r != ST_IDLE) || out_valid_r;
  assign out_valid = out_valid_r;
  assign out_res   = out_r;

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after an item was taken");

  a_gcd_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_GCD) |-> (u_r != '0 && v_r != '0))
    else $error("GCD operand reached zero");

  a_equal_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_res.is_equal) |-> (out_res.res_num == '0 && out_res.res_den == '0))
    else $error("compare result carries a fraction");

endmodule

// ===== tb/sv/rau_result_checker.sv =====
// rau_result_checker: watches both channels of rational_arith_unit_core, predicts
// the reduced fraction or compare flag for every item taken and checks each result.
// Depends on rau_pkg.
module rau_result_checker
  import rau_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  logic     busy,
  input  rau_req_t in_req,
  input  logic     out_valid,
  input  rau_res_t out_res,
  output int       mismatches,
  output int       outstanding,
  output int       checked
);

  rau_res_t predicted_q[$];
  int       n_bad     = 0;
  int       n_checked = 0;

  assign mismatches = n_bad;
  assign checked    = n_checked;

  initial outstanding = 0;

  function automatic longint gcd_of(longint x, longint y);
    longint t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  // Divide out the common factor of |num| and den; zero on either side passes through.
  function automatic rau_res_t reduce_frac(longint num, longint den);
    rau_res_t res;
    longint   mag;
    longint   g;
    if (num != 0 && den != 0) begin
      mag = (num < 0) ? -num : num;
      g   = gcd_of(mag, den);
      if (g > 1) begin
        mag = mag / g;
        den = den / g;
      end
      num = (num < 0) ? -mag : mag;
    end
    res.res_num  = num[RES_NUM_W-1:0];
    res.res_den  = den[RES_DEN_W-1:0];
    res.is_equal = 1'b0;
    return res;
  endfunction

  function automatic rau_res_t predict_result(rau_req_t r);
    rau_res_t res;
    longint   an;
    longint   bn;
    longint   ad;
    longint   bd;
    an = longint'($signed(r.a_num));
    bn = longint'($signed(r.b_num));
    ad = longint'(r.a_den);
    bd = longint'(r.b_den);
    case (r.req_type)
      OP_ADD: res = reduce_frac(an * bd + bn * ad, ad * bd);
      OP_MUL: res = reduce_frac(an * bn, ad * bd);
      OP_EQU: begin
        res          = '0;
        res.is_equal = (r.a_num == r.b_num) && (r.a_den == r.b_den);
      end
      default: res = reduce_frac(an + ad, ad);
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    rau_res_t want;
    if (rst_n) begin
      // retire the result first: it belongs to an item taken earlier
      if (out_valid) begin
        if (predicted_q.size() == 0) begin
          $error("result with no item outstanding: res_num %0d res_den %0d is_equal %0d",
                 out_res.res_num, out_res.res_den, out_res.is_equal);
          n_bad++;
        end else begin
          want = predicted_q.pop_front();
          n_checked++;
          if (out_res.res_num !== want.res_num) begin
            $error("res_num: expected %0d, got %0d", want.res_num, out_res.res_num);
            n_bad++;
          end
          if (out_res.res_den !== want.res_den) begin
            $error("res_den: expected %0d, got %0d", want.res_den, out_res.res_den);
            n_bad++;
          end
          if (out_res.is_equal !== want.is_equal) begin
            $error("is_equal: expected %0d, got %0d", want.is_equal, out_res.is_equal);
            n_bad++;
          end
        end
      end
      if (start && !busy) begin
        predicted_q.push_back(predict_result(in_req));
      end
      outstanding <= predicted_q.size();
    end
  end

endmodule

// ===== tb/sv/tb.sv =====
// tb: stimulus and verdict for rational_arith_unit_core; directed fractions first,
// then random items over phases of sender idling. Depends on rau_pkg and rau_result_checker.
module tb;
  import rau_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int RAND_ITEMS  = 1650;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     start     = 1'b0;
  rau_req_t in_req    = '0;
  logic     busy;
  logic     out_valid;
  rau_res_t out_res;
  int       mismatches;
  int       outstanding;
  int       checked;
  int       op_count[4];
  int       idle_pct[4] = '{0, 58, 0, 11};

  always #6 clk = ~clk;

  rational_arith_unit_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  rau_result_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_req      (in_req),
    .out_valid   (out_valid),
    .out_res     (out_res),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .checked     (checked)
  );

  // Hold the item until taken, then idle for a random stretch if the phase asks.
  task automatic issue(rau_req_t r, int pct);
    in_req <= r;
    start  <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    op_count[r.req_type]++;
    if ($urandom_range(99) < pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 250)) @(posedge clk);
    end
  endtask

  task automatic send_frac(logic [1:0] op, int an, int ad, int bn, int bd);
    rau_req_t r;
    r.req_type = op;
    r.a_num    = an[NUM_W-1:0];
    r.a_den    = ad[DEN_W-1:0];
    r.b_num    = bn[NUM_W-1:0];
    r.b_den    = bd[DEN_W-1:0];
    issue(r, 0);
  endtask

  // Drop start and wait until every result has come back.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  function automatic logic [NUM_W-1:0] rand_num();
    logic [NUM_W-1:0] v;
    case ($urandom_range(9))
      0, 1, 2, 3: v = NUM_W'($urandom);
      4, 5:       v = NUM_W'($urandom_range(0, 40));
      6:          v = -NUM_W'($urandom_range(1, 40));
      7:          v = $urandom_range(1) ? {1'b1, {(NUM_W-1){1'b0}}} : {1'b0, {(NUM_W-1){1'b1}}};
      default:    v = NUM_W'($urandom_range(1, 60) * $urandom_range(1, 500));
    endcase
    return v;
  endfunction

  function automatic logic [DEN_W-1:0] rand_den();
    logic [DEN_W-1:0] v;
    case ($urandom_range(19))
      0:                v = '0;
      1:                v = '1;
      2, 3, 4, 5, 6, 7: v = DEN_W'($urandom_range(1, 40));
      8, 9, 10:         v = DEN_W'($urandom_range(1, 60) * $urandom_range(1, 500));
      default:          v = DEN_W'($urandom);
    endcase
    return v;
  endfunction

  initial begin : quiet_watch
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || out_valid) quiet = 0;
      else quiet++;
    end
    $display("FAIL rational_arith_unit_core");
    $finish;
  end

  initial begin : stimulus
    rau_req_t r;
    int       per_phase;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // field extremes, each operation, zero numerators and zero denominators
    send_frac(OP_ADD, 1, 2, 1, 3);
    send_frac(OP_ADD, 1, 2, -1, 2);
    send_frac(OP_ADD, -32768, 32767, -32768, 32767);
    send_frac(OP_ADD, 32767, 1, 32767, 1);
    send_frac(OP_ADD, 6, 4, 0, 32767);
    send_frac(OP_ADD, 0, 0, 0, 0);
    send_frac(OP_MUL, 0, 7, 5, 3);
    send_frac(OP_MUL, -32768, 1, -32768, 1);
    send_frac(OP_MUL, -6, 4, 2, 9);
    send_frac(OP_MUL, 32767, 32767, -32768, 32767);
    send_frac(OP_MUL, 3, 0, 5, 2);
    send_frac(OP_EQU, 3, 4, 3, 4);
    send_frac(OP_EQU, 3, 4, 3, 5);
    send_frac(OP_EQU, 3, 4, -3, 4);
    send_frac(OP_EQU, -32768, 32767, -32768, 32767);
    send_frac(OP_EQU, 5, 0, 5, 0);
    send_frac(OP_EQU, 0, 1, 0, 0);
    send_frac(OP_INC, -5, 5, 9, 9);
    send_frac(OP_INC, 32767, 32767, 0, 1);
    send_frac(OP_INC, -32768, 1, 1, 1);
    send_frac(OP_INC, 7, 0, 1, 1);
    send_frac(OP_INC, -12, 8, -1, 3);
    drain();

    per_phase = RAND_ITEMS / 4;
    foreach (idle_pct[p]) begin
      for (int i = 0; i < per_phase; i++) begin
        r.req_type = 2'($urandom_range(3));
        r.a_num    = rand_num();
        r.a_den    = rand_den();
        r.b_num    = rand_num();
        r.b_den    = rand_den();
        // give compare a fair share of matching pairs
        if (r.req_type == OP_EQU && $urandom_range(1)) begin
          r.b_num = r.a_num;
          r.b_den = r.a_den;
        end
        issue(r, idle_pct[p]);
      end
      drain();
    end

    // let any stray result surface before the verdict
    repeat (250) @(posedge clk);
    $display("Sent %0d add, %0d multiply, %0d compare and %0d increment items;",
             op_count[OP_ADD], op_count[OP_MUL], op_count[OP_EQU], op_count[OP_INC]);
    $display("checked %0d results across four idling phases, %0d mismatches.",
             checked, mismatches);
    if (mismatches == 0 && outstanding == 0) begin
      $display("PASS rational_arith_unit_core");
    end else begin
      $display("FAIL rational_arith_unit_core");
    end
    $finish;
  end

endmodule
